### rtl/core/rgb_to_hsv_converter_macros.svh
// Assertion helpers used by the converter's checker.
`ifndef RGB_TO_HSV_CONVERTER_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RHC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RHC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/rhc_pkg.sv
package rhc_pkg;

   // Default component width
   localparam int unsigned COMPONENT_BITS_DEFAULT = 8;

   // Hue encoding: 256 units per 60 degrees, full turn 1536
   localparam int unsigned HUE_BITS   = 11;
   localparam int unsigned HUE_Q_BITS = 9;   // offset quotient 0..256
   localparam int unsigned HUE_FRAC   = 8;   // log2 of units per sector
   localparam logic [HUE_BITS-1:0] HUE_TURN       = 11'd1536;
   localparam logic [HUE_BITS-1:0] HUE_BASE_RED   = 11'd0;
   localparam logic [HUE_BITS-1:0] HUE_BASE_GREEN = 11'd512;
   localparam logic [HUE_BITS-1:0] HUE_BASE_BLUE  = 11'd1024;

   // Which component holds the maximum
   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

   function automatic logic [HUE_BITS-1:0] hue_base(input sector_type sector);
      logic [HUE_BITS-1:0] base;
      case (sector)
         SECTOR_RED: begin
            base = HUE_BASE_RED;
         end
         SECTOR_GREEN: begin
            base = HUE_BASE_GREEN;
         end
         SECTOR_BLUE: begin
            base = HUE_BASE_BLUE;
         end
         default: begin
            base = HUE_BASE_RED;
         end
      endcase
      return base;
   endfunction

endpackage

### rtl/core/rgb_to_hsv_converter.sv
// RGB to HSV pixel converter.
// Input stream req_*: one pixel per item, red, green and blue of COMPONENT_BITS each.
// Result stream rsp_*: one item per pixel, hue (11 bits, 256 units per 60 degrees,
// 0..1535), saturation floor(max_code*(max-min)/max) and brightness (the largest
// component). Grey and black pixels give hue 0; black gives saturation 0.
// Throughput: one pixel per clock, sustained, for as long as the receiver takes
// results. The pipeline holds input, compare and set-up stages, then the stages
// of the two restoring dividers (saturation and hue offset), which run side by
// side and retire one quotient bit each per pipeline stage until each is done.
// The pipeline moves as a whole and feeds a two-entry result buffer, so it keeps
// taking items while one finished result waits; it stops only when both entries
// are full and rsp_tready is low. Nothing is lost or repeated under stall.
// Reset (synchronous, active high) empties the pipeline and the result buffer.
module rgb_to_hsv_converter #(
   parameter int unsigned COMPONENT_BITS = rhc_pkg::COMPONENT_BITS_DEFAULT
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_tvalid,
   output logic                                        req_tready,
   // red, green, blue from bit 0 up, zero padded to bytes
   input  logic [((3*COMPONENT_BITS+7)/8)*8-1:0]       req_tdata,
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   // hue (11), saturation, brightness from bit 0 up, zero padded to bytes
   output logic [((rhc_pkg::HUE_BITS+2*COMPONENT_BITS+7)/8)*8-1:0] rsp_tdata
);

   import rhc_pkg::*;

   localparam int unsigned N         = COMPONENT_BITS;
   localparam int unsigned OUT_W     = ((HUE_BITS + 2*COMPONENT_BITS + 7) / 8) * 8;
   localparam int unsigned PAYLOAD_W = HUE_BITS + 2*COMPONENT_BITS;
   localparam int unsigned DIV_STEPS = (COMPONENT_BITS > HUE_Q_BITS) ? COMPONENT_BITS
                                                                     : HUE_Q_BITS;
   localparam int unsigned LAST      = DIV_STEPS + 2;

   typedef struct packed {
      logic [N-1:0] red;
      logic [N-1:0] green;
      logic [N-1:0] blue;
   } pix_type;

   typedef struct packed {
      logic [N-1:0] max;
      logic [N-1:0] min;
      logic [N-1:0] pos;
      logic [N-1:0] neg;
      sector_type   sector;
   } cmp_type;

   typedef struct packed {
      logic [N-1:0]            max;
      logic [N-1:0]            delta;
      logic                    delta_zero;
      logic                    negative;
      sector_type              sector;
      logic [N-1:0]            sat_rem;
      logic [N-1:0]            sat_low;
      logic [N-1:0]            sat_quo;
      logic [N-1:0]            hue_rem;
      logic [HUE_Q_BITS-1:0]   hue_low;
      logic [HUE_Q_BITS-1:0]   hue_quo;
   } div_type;

   // Pipeline control
   logic            advance;
   logic [LAST:0]   vld_ff;
   logic [LAST:0]   vld_in;

   // Stage payloads
   pix_type         pix_ff;
   pix_type         pix_in;
   cmp_type         cmp_ff;
   cmp_type         cmp_in;
   div_type         div_ff [0:DIV_STEPS];
   div_type         div_in;

   // Result buffer
   logic [PAYLOAD_W-1:0] ent0_ff;
   logic [PAYLOAD_W-1:0] ent1_ff;
   logic [1:0]           cnt_ff;
   logic                 push;
   logic                 pop;
   logic [PAYLOAD_W-1:0] result;

   logic [N-1:0]          delta;
   logic [N-1:0]          mag;
   logic                  negative;
   logic [2*N-1:0]        sat_dividend;
   logic [HUE_BITS-1:0]   hue_val;
   logic [HUE_BITS-1:0]   hue_base_val;
   logic [HUE_BITS-1:0]   hue_off;
   logic [N-1:0]          sat_val;

   // Whole pipeline steps unless the result buffer is full and not draining
   assign pop        = rsp_tvalid && rsp_tready;
   assign advance    = (cnt_ff != 2'd2) || rsp_tready;
   assign req_tready = advance;
   assign push       = advance && vld_ff[LAST];

   assign vld_in = {vld_ff[LAST-1:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   // Stage 0: input register
   assign pix_in.red   = req_tdata[N-1:0];
   assign pix_in.green = req_tdata[2*N-1:N];
   assign pix_in.blue  = req_tdata[3*N-1:2*N];

   always_ff @(posedge clock) begin
      if (advance) begin
         pix_ff <= pix_in;
      end
   end

   // Stage 1: max, min and sector (red wins ties, then green)
   always_comb begin
      cmp_in.max = pix_ff.red;
      cmp_in.min = pix_ff.red;
      if (pix_ff.blue > cmp_in.max) begin
         cmp_in.max = pix_ff.blue;
      end
      if (pix_ff.green > cmp_in.max) begin
         cmp_in.max = pix_ff.green;
      end
      if (pix_ff.blue < cmp_in.min) begin
         cmp_in.min = pix_ff.blue;
      end
      if (pix_ff.green < cmp_in.min) begin
         cmp_in.min = pix_ff.green;
      end
      if (pix_ff.red == cmp_in.max) begin
         cmp_in.sector = SECTOR_RED;
         cmp_in.pos    = pix_ff.green;
         cmp_in.neg    = pix_ff.blue;
      end else if (pix_ff.green == cmp_in.max) begin
         cmp_in.sector = SECTOR_GREEN;
         cmp_in.pos    = pix_ff.blue;
         cmp_in.neg    = pix_ff.red;
      end else begin
         cmp_in.sector = SECTOR_BLUE;
         cmp_in.pos    = pix_ff.red;
         cmp_in.neg    = pix_ff.green;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cmp_ff <= cmp_in;
      end
   end

   // Stage 2: chroma, offset magnitude and divider set-up.
   // Saturation divides max_code*delta by max; hue divides mag*256 by delta.
   // Both quotients fit their widths, so the upper dividend bits seed the remainder.
   assign delta        = cmp_ff.max - cmp_ff.min;
   assign negative     = cmp_ff.pos < cmp_ff.neg;
   assign mag          = negative ? (cmp_ff.neg - cmp_ff.pos) : (cmp_ff.pos - cmp_ff.neg);
   assign sat_dividend = {delta, {N{1'b0}}} - {{N{1'b0}}, delta};

   always_comb begin
      div_in.max        = cmp_ff.max;
      div_in.delta      = delta;
      div_in.delta_zero = (delta == '0);
      div_in.negative   = negative;
      div_in.sector     = cmp_ff.sector;
      div_in.sat_rem    = sat_dividend[2*N-1:N];
      div_in.sat_low    = sat_dividend[N-1:0];
      div_in.sat_quo    = '0;
      div_in.hue_rem    = mag >> 1;
      div_in.hue_low    = {mag[0], {HUE_FRAC{1'b0}}};
      div_in.hue_quo    = '0;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         div_ff[0] <= div_in;
      end
   end

   // Divider stages: one quotient bit of each divider per stage, while it still has bits to retire
   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      logic [N:0] sat_trial;
      logic [N:0] hue_trial;
      div_type    nxt;

      always_comb begin
         nxt       = div_ff[j];
         sat_trial = {div_ff[j].sat_rem, div_ff[j].sat_low[N-1]};
         hue_trial = {div_ff[j].hue_rem, div_ff[j].hue_low[HUE_Q_BITS-1]};
         if (j < N) begin
            nxt.sat_low = div_ff[j].sat_low << 1;
            if (sat_trial >= {1'b0, div_ff[j].max}) begin
               nxt.sat_rem = N'(sat_trial - {1'b0, div_ff[j].max});
               nxt.sat_quo = {div_ff[j].sat_quo[N-2:0], 1'b1};
            end else begin
               nxt.sat_rem = sat_trial[N-1:0];
               nxt.sat_quo = {div_ff[j].sat_quo[N-2:0], 1'b0};
            end
         end
         if (j < HUE_Q_BITS) begin
            nxt.hue_low = div_ff[j].hue_low << 1;
            if (hue_trial >= {1'b0, div_ff[j].delta}) begin
               nxt.hue_rem = N'(hue_trial - {1'b0, div_ff[j].delta});
               nxt.hue_quo = {div_ff[j].hue_quo[HUE_Q_BITS-2:0], 1'b1};
            end else begin
               nxt.hue_rem = hue_trial[N-1:0];
               nxt.hue_quo = {div_ff[j].hue_quo[HUE_Q_BITS-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            div_ff[j+1] <= nxt;
         end
      end
   end

   // Final assembly: sector base plus signed offset, red wraps below zero
   assign hue_base_val = hue_base(div_ff[DIV_STEPS].sector);
   assign hue_off      = HUE_BITS'(div_ff[DIV_STEPS].hue_quo);

   always_comb begin
      if (div_ff[DIV_STEPS].delta_zero) begin
         hue_val = '0;
         sat_val = '0;
      end else begin
         sat_val = div_ff[DIV_STEPS].sat_quo;
         if (!div_ff[DIV_STEPS].negative) begin
            hue_val = hue_base_val + hue_off;
         end else if (hue_off > hue_base_val) begin
            hue_val = hue_base_val + HUE_TURN - hue_off;
         end else begin
            hue_val = hue_base_val - hue_off;
         end
      end
   end

   assign result = {div_ff[DIV_STEPS].max, sat_val, hue_val};

   // Two-entry result buffer, entry 0 is the head
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         case ({push, pop})
            2'b10: begin
               cnt_ff <= cnt_ff + 2'd1;
            end
            2'b01: begin
               cnt_ff <= cnt_ff - 2'd1;
            end
            default: begin
               cnt_ff <= cnt_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case ({push, pop})
         2'b10: begin
            if (cnt_ff == 2'd0) begin
               ent0_ff <= result;
            end else begin
               ent1_ff <= result;
            end
         end
         2'b01: begin
            ent0_ff <= ent1_ff;
         end
         2'b11: begin
            if (cnt_ff == 2'd1) begin
               ent0_ff <= result;
            end else begin
               ent0_ff <= ent1_ff;
               ent1_ff <= result;
            end
         end
         default: begin
            ent0_ff <= ent0_ff;
         end
      endcase
   end

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = OUT_W'(ent0_ff);

endmodule

### rtl/core/rhc_checker.sv
`include "rgb_to_hsv_converter_macros.svh"

module rhc_checker #(
   parameter int unsigned COMPONENT_BITS = rhc_pkg::COMPONENT_BITS_DEFAULT
) (
   input logic                                        clock,
   input logic                                        reset,
   input logic                                        req_tvalid,
   input logic                                        req_tready,
   // red, green, blue from bit 0 up
   input logic [((3*COMPONENT_BITS+7)/8)*8-1:0]       req_tdata,
   input logic                                        rsp_tvalid,
   input logic                                        rsp_tready,
   // hue, saturation, brightness from bit 0 up
   input logic [((rhc_pkg::HUE_BITS+2*COMPONENT_BITS+7)/8)*8-1:0] rsp_tdata
);

   import rhc_pkg::*;

   logic [HUE_BITS-1:0]       hue;
   logic [COMPONENT_BITS-1:0] sat;
   logic [COMPONENT_BITS-1:0] bright;
   logic                      in_item;

   assign hue     = rsp_tdata[HUE_BITS-1:0];
   assign sat     = rsp_tdata[HUE_BITS +: COMPONENT_BITS];
   assign bright  = rsp_tdata[HUE_BITS+COMPONENT_BITS +: COMPONENT_BITS];
   assign in_item = req_tvalid && req_tready && (req_tdata == req_tdata);

   // A stalled result stays put
   `RHC_ASSERT_NEXT(ap_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")

   // Hue stays below a full turn
   `RHC_ASSERT_NOW(ap_hue_range, clock, reset, rsp_tvalid, hue < HUE_TURN, "hue out of range")

   // Grey pixels carry no hue
   `RHC_ASSERT_NOW(ap_grey_hue, clock, reset, rsp_tvalid && (sat == '0), hue == '0, "grey pixel with hue")

   // Black pixels carry no saturation
   `RHC_ASSERT_NOW(ap_black_sat, clock, reset, rsp_tvalid && (bright == '0), sat == '0, "black pixel with saturation")

   // No result straight after reset, checked in reset cycles that accept no item
   `RHC_ASSERT_NEXT(ap_reset_empty, clock, 1'b0, reset && !in_item, !rsp_tvalid, "result after reset")

endmodule

bind rgb_to_hsv_converter rhc_checker #(
   .COMPONENT_BITS(COMPONENT_BITS)
) u_rhc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
